FILE: rtl/quota_lru_eviction_table_defines.svh
// ----------------------------------------------------------------------------
// Quota LRU eviction table assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTA_LRU_EVICTION_TABLE_DEFINES_SVH
`define QUOTA_LRU_EVICTION_TABLE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define QLET_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define QLET_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/qlet_pkg.sv
// ----------------------------------------------------------------------------
// Quota LRU eviction table package
// Shared field widths, operation and status codes, types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qlet_pkg;

   localparam int ID_W     = 31;
   localparam int BYTES_W  = 40;
   localparam int QUOTA_W  = 44;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int STAMP_W  = 64;
   localparam int SIZE_MAX_W = 48;

   localparam logic [ID_W-1:0] ID_MAX = '1;

   typedef enum logic [2:0] {
      KIND_BEGIN  = 3'd0,
      KIND_COMMIT = 3'd1,
      KIND_ABORT  = 3'd2,
      KIND_TOUCH  = 3'd3,
      KIND_TRIM   = 3'd4
   } kind_type;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_ROOM   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_IDS_OUT   = 3'd4;

   localparam logic CSR_QUOTA    = 1'b0;
   localparam logic CSR_FIRST_ID = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_TRIM_CHECK,
      S_SCAN,
      S_EVICT,
      S_ALLOC,
      S_STATUS
   } state_type;

   // Classified operation handed from the front end to the engine.
   typedef struct packed {
      kind_type               kind;
      logic [ID_W-1:0]        sid;
      logic [BYTES_W-1:0]     reserve;
      logic [SIZE_MAX_W-1:0]  size;
   } op_type;

   typedef struct packed {
      logic                   is_eviction;
      logic [ID_W-1:0]        result_id;
      logic [BYTES_W-1:0]     entry_bytes;
      logic [STATUS_W-1:0]    status;
      logic [QUOTA_W-1:0]     total_bytes;
      logic [COUNT_W-1:0]     entry_count;
      logic                   stuck_pinned;
      logic                   last;
   } rsp_type;

   function automatic logic [QUOTA_W-1:0] sat_total(input logic [63:0] v);
      logic [63:0] lim;
      lim = {{(64-QUOTA_W){1'b0}}, {QUOTA_W{1'b1}}};
      return (v > lim) ? lim[QUOTA_W-1:0] : v[QUOTA_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] sat_count(input logic [7:0] c);
      logic [7:0] lim;
      lim = {{(8-COUNT_W){1'b0}}, {COUNT_W{1'b1}}};
      return (c > lim) ? lim[COUNT_W-1:0] : c[COUNT_W-1:0];
   endfunction

endpackage

FILE: rtl/qlet_front.sv
// ----------------------------------------------------------------------------
// Quota LRU eviction table front end
// Accepts request words, decodes the kind, clamps the size and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlet_front #(
   parameter int SIZE_BITS = 40
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_kind,
   input  logic [qlet_pkg::ID_W-1:0]   req_sid,
   input  logic [qlet_pkg::BYTES_W-1:0] req_reserve,
   input  logic [qlet_pkg::BYTES_W-1:0] req_size,
   output logic                        op_valid,
   input  logic                        op_ready,
   output qlet_pkg::op_type            op
);
   import qlet_pkg::*;

   localparam logic [SIZE_MAX_W-1:0] SIZE_LIM = {SIZE_MAX_W{1'b1}} >> (SIZE_MAX_W - SIZE_BITS);

   op_type       fifo_ff [2];
   op_type       fifo_in [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;
   op_type       entry;
   logic [SIZE_MAX_W-1:0] size_wide;
   logic         push, pop;

   assign size_wide = SIZE_MAX_W'(req_size);

   always_comb begin
      entry.kind    = kind_type'(req_kind);
      entry.sid     = req_sid;
      entry.reserve = req_reserve;
      entry.size    = (size_wide > SIZE_LIM) ? SIZE_LIM : size_wide;
   end

   assign req_ready = (fill_ff != 2'd2);
   assign op_valid  = (fill_ff != 2'd0);
   assign op        = fifo_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = op_valid && op_ready;

   always_comb begin
      fifo_in   = fifo_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         fifo_in[wr_ptr_ff] = entry;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
   end

endmodule

FILE: rtl/qlet_engine.sv
// ----------------------------------------------------------------------------
// Quota LRU eviction table engine
// Owns the entry table and runs each operation, scanning once per eviction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "quota_lru_eviction_table_defines.svh"

module qlet_engine #(
   parameter int ENTRIES   = 16,
   parameter int SIZE_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [qlet_pkg::QUOTA_W-1:0]  csr_wdata,
   input  logic                          op_valid,
   output logic                          op_ready,
   input  qlet_pkg::op_type              op,
   output logic                          out_valid,
   input  logic                          out_ready,
   output qlet_pkg::rsp_type             out_item
);
   import qlet_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int TOT_W = SIZE_BITS + IDX_W + 1;

   state_type            state_ff, state_in;
   op_type               cur_ff, cur_in;
   logic [BYTES_W-1:0]   headroom_ff, headroom_in;
   logic                 after_begin_ff, after_begin_in;
   logic                 stuck_ff, stuck_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [ID_W-1:0]      rid_ff, rid_in;

   logic [QUOTA_W-1:0]   quota_ff, quota_in;
   logic [ID_W-1:0]      next_id_ff, next_id_in;
   logic [STAMP_W-1:0]   clock_ff, clock_in;

   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [ENTRIES-1:0]   pinned_ff, pinned_in;
   logic [ID_W-1:0]      id_ff [ENTRIES];
   logic [ID_W-1:0]      id_in [ENTRIES];
   logic [SIZE_BITS-1:0] size_ff [ENTRIES];
   logic [SIZE_BITS-1:0] size_in [ENTRIES];
   logic [STAMP_W-1:0]   stamp_ff [ENTRIES];
   logic [STAMP_W-1:0]   stamp_in [ENTRIES];
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_ff, best_in;
   logic [STAMP_W-1:0]   best_stamp_ff, best_stamp_in;
   logic [ID_W-1:0]      best_id_ff, best_id_in;
   logic [SIZE_BITS-1:0] best_size_ff, best_size_in;

   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;

   // Shared decode.
   logic [ENTRIES-1:0]   hit;
   logic                 hit_any;
   logic [IDX_W-1:0]     match_idx;
   logic                 free_any;
   logic [IDX_W-1:0]     free_idx;
   logic [IDX_W-1:0]     rd_addr;
   logic [SIZE_BITS-1:0] rd_size;
   logic                 out_free;
   logic                 over;
   logic                 cand;
   logic                 better;
   logic                 found_next;
   logic                 scan_end;
   logic [TOT_W-1:0]     tot_evict;
   logic [SIZE_MAX_W-1:0] best_wide;

   always_comb begin
      hit       = '0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         hit[i] = valid_ff[i] && (id_ff[i] == cur_ff.sid);
         if (hit[i]) begin
            match_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any   = |hit;
   assign free_any  = ~&valid_ff;
   assign rd_addr   = (state_ff == S_SCAN) ? idx_ff : match_idx;
   assign rd_size   = size_ff[rd_addr];
   assign out_free  = !out_valid_ff || out_ready;
   assign over      = (quota_ff != '0) &&
                      ((64'(total_ff) + 64'(headroom_ff)) > 64'(quota_ff));
   assign cand      = valid_ff[idx_ff] && !pinned_ff[idx_ff];
   assign better    = cand && (!found_ff || (stamp_ff[idx_ff] < best_stamp_ff));
   assign found_next = found_ff || cand;
   assign scan_end  = (idx_ff == IDX_W'(ENTRIES - 1));
   assign tot_evict = total_ff - TOT_W'(best_size_ff);
   assign best_wide = SIZE_MAX_W'(best_size_ff);

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (cur_ff.kind)
               KIND_BEGIN:  state_in = (next_id_ff == '0) ? S_STATUS : S_TRIM_CHECK;
               KIND_COMMIT: state_in = hit_any ? S_TRIM_CHECK : S_STATUS;
               KIND_TRIM:   state_in = S_TRIM_CHECK;
               default:     state_in = S_STATUS;
            endcase
         end
         S_TRIM_CHECK: begin
            if (over) begin
               state_in = S_SCAN;
            end else begin
               state_in = after_begin_ff ? S_ALLOC : S_STATUS;
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               if (found_next) begin
                  state_in = S_EVICT;
               end else begin
                  state_in = after_begin_ff ? S_ALLOC : S_STATUS;
               end
            end
         end
         S_EVICT: begin
            if (out_free) begin
               state_in = S_TRIM_CHECK;
            end
         end
         S_ALLOC:  state_in = S_STATUS;
         S_STATUS: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      op_ready = (state_ff == S_IDLE);
   end

   // Datapath next values.
   always_comb begin
      cur_in         = cur_ff;
      headroom_in    = headroom_ff;
      after_begin_in = after_begin_ff;
      stuck_in       = stuck_ff;
      status_in      = status_ff;
      rid_in         = rid_ff;
      quota_in       = quota_ff;
      next_id_in     = next_id_ff;
      clock_in       = clock_ff;
      valid_in       = valid_ff;
      pinned_in      = pinned_ff;
      id_in          = id_ff;
      size_in        = size_ff;
      stamp_in       = stamp_ff;
      total_in       = total_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_stamp_in  = best_stamp_ff;
      best_id_in     = best_id_ff;
      best_size_in   = best_size_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_in         = out_ff;

      if (csr_we) begin
         if (csr_addr == CSR_QUOTA) begin
            quota_in = csr_wdata;
         end else begin
            next_id_in = (csr_wdata[ID_W-1:0] == '0) ? ID_W'(1) : csr_wdata[ID_W-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               cur_in = op;
            end
         end
         S_DISPATCH: begin
            stuck_in       = 1'b0;
            status_in      = STAT_OK;
            rid_in         = '0;
            after_begin_in = 1'b0;
            headroom_in    = '0;
            unique case (cur_ff.kind)
               KIND_BEGIN: begin
                  if (next_id_ff == '0) begin
                     status_in = STAT_IDS_OUT;
                  end else begin
                     headroom_in    = cur_ff.reserve;
                     after_begin_in = 1'b1;
                  end
               end
               KIND_COMMIT: begin
                  rid_in = cur_ff.sid;
                  if (!hit_any) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     size_in[match_idx]   = cur_ff.size[SIZE_BITS-1:0];
                     total_in             = total_ff - TOT_W'(rd_size) +
                                            TOT_W'(cur_ff.size[SIZE_BITS-1:0]);
                     clock_in             = clock_ff + STAMP_W'(1);
                     stamp_in[match_idx]  = clock_ff + STAMP_W'(1);
                     pinned_in[match_idx] = 1'b0;
                  end
               end
               KIND_ABORT: begin
                  rid_in = cur_ff.sid;
                  if (!hit_any) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     valid_in[match_idx]  = 1'b0;
                     pinned_in[match_idx] = 1'b0;
                     total_in             = total_ff - TOT_W'(rd_size);
                     count_in             = count_ff - CNT_W'(1);
                  end
               end
               KIND_TOUCH: begin
                  rid_in = cur_ff.sid;
                  if (!hit_any) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     clock_in            = clock_ff + STAMP_W'(1);
                     stamp_in[match_idx] = clock_ff + STAMP_W'(1);
                  end
               end
               KIND_TRIM: begin
                  headroom_in = cur_ff.reserve;
               end
               default: begin
               end
            endcase
         end
         S_TRIM_CHECK: begin
            idx_in   = '0;
            found_in = 1'b0;
         end
         S_SCAN: begin
            if (better) begin
               best_in       = idx_ff;
               best_stamp_in = stamp_ff[idx_ff];
               best_id_in    = id_ff[idx_ff];
               best_size_in  = rd_size;
            end
            found_in = found_next;
            if (scan_end) begin
               if (!found_next) begin
                  stuck_in = 1'b1;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_EVICT: begin
            if (out_free) begin
               valid_in[best_ff]    = 1'b0;
               pinned_in[best_ff]   = 1'b0;
               total_in             = tot_evict;
               count_in             = count_ff - CNT_W'(1);
               out_valid_in         = 1'b1;
               out_in.is_eviction   = 1'b1;
               out_in.result_id     = best_id_ff;
               out_in.entry_bytes   = best_wide[BYTES_W-1:0];
               out_in.status        = STAT_OK;
               out_in.total_bytes   = sat_total(64'(tot_evict));
               out_in.entry_count   = sat_count(8'(count_ff - CNT_W'(1)));
               out_in.stuck_pinned  = 1'b0;
               out_in.last          = 1'b0;
            end
         end
         S_ALLOC: begin
            if (over) begin
               status_in = STAT_NO_ROOM;
            end else if (!free_any) begin
               status_in = STAT_FULL;
            end else begin
               valid_in[free_idx]  = 1'b1;
               pinned_in[free_idx] = 1'b1;
               id_in[free_idx]     = next_id_ff;
               size_in[free_idx]   = '0;
               clock_in            = clock_ff + STAMP_W'(1);
               stamp_in[free_idx]  = clock_ff + STAMP_W'(1);
               count_in            = count_ff + CNT_W'(1);
               rid_in              = next_id_ff;
               next_id_in          = (next_id_ff == ID_MAX) ? '0 : next_id_ff + ID_W'(1);
            end
         end
         S_STATUS: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               out_in.is_eviction   = 1'b0;
               out_in.result_id     = rid_ff;
               out_in.entry_bytes   = '0;
               out_in.status        = status_ff;
               out_in.total_bytes   = sat_total(64'(total_ff));
               out_in.entry_count   = sat_count(8'(count_ff));
               out_in.stuck_pinned  = stuck_ff;
               out_in.last          = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         quota_ff     <= '0;
         next_id_ff   <= ID_W'(1);
         clock_ff     <= '0;
         valid_ff     <= '0;
         pinned_ff    <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         quota_ff     <= quota_in;
         next_id_ff   <= next_id_in;
         clock_ff     <= clock_in;
         valid_ff     <= valid_in;
         pinned_ff    <= pinned_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      headroom_ff    <= headroom_in;
      after_begin_ff <= after_begin_in;
      stuck_ff       <= stuck_in;
      status_ff      <= status_in;
      rid_ff         <= rid_in;
      id_ff          <= id_in;
      size_ff        <= size_in;
      stamp_ff       <= stamp_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      best_ff        <= best_in;
      best_stamp_ff  <= best_stamp_in;
      best_id_ff     <= best_id_in;
      best_size_ff   <= best_size_in;
      out_ff         <= out_in;
   end

   `QLET_ASSERT_NOW(a_count_tracks_valid, 1'b1, $countones(valid_ff) == int'(count_ff), "entry count differs from valid bits")
   `QLET_ASSERT_NOW(a_pinned_only_valid, 1'b1, (pinned_ff & ~valid_ff) == '0, "pinned bit set on an empty slot")
   `QLET_ASSERT_NEXT(a_status_ends_op, state_ff == S_STATUS && out_free, state_ff == S_IDLE && out_valid_ff && out_ff.last, "status word did not close the operation")
   `QLET_ASSERT_NOW(a_evict_word_clean, out_valid_ff && out_ff.is_eviction, out_ff.status == STAT_OK && !out_ff.last && !out_ff.stuck_pinned, "eviction word carries status fields")

endmodule

FILE: rtl/quota_lru_eviction_table.sv
// ----------------------------------------------------------------------------
// Quota LRU eviction table
// Sized entries under a byte quota with least-recently-updated eviction.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Words                      Handshake
//   req_*     in    one operation              tvalid/tready
//   rsp_*     out   evictions, then a status   tvalid/tready, tlast on status
//   csr_*     in    register write             csr_we, no wait
//
// An operation leaves the queue in the idle state and is decoded in the
// dispatch state. Each eviction passes through a check, a scan of the stamps
// over all ENTRIES slots and a state that hands out the eviction word. The
// trim loop ends with one more check, plus one last scan when only pinned
// entries are left over quota. Begin adds an allocation step, and then the
// status word is sent. Reset is synchronous and leaves the table empty with
// no clearing pass. A two-word queue takes requests while the engine works,
// and the engine waits only when its output register is still held by
// rsp_tready.
//
// The engine works one operation at a time. Every word reports the running
// byte total and entry count right after the event it describes, so a
// downstream consumer can track occupancy without reading the table.
`timescale 1ns / 1ps

module quota_lru_eviction_table #(
   parameter int ENTRIES   = 16,
   parameter int SIZE_BITS = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [111:0]                 req_tdata,  // session_id, reserve_bytes, size_bytes
   input  logic [2:0]                   req_tuser,  // kind
   // Result channel.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [127:0]                 rsp_tdata,  // result_id, entry_bytes, status,
                                                    // total_bytes, entry_count, stuck_pinned
   output logic                         rsp_tuser,  // is_eviction
   output logic                         rsp_tlast,  // last
   // Register writes: index 0 is quota_bytes, index 1 is first_id.
   input  logic                         csr_we,
   input  logic                         csr_addr,
   input  logic [qlet_pkg::QUOTA_W-1:0] csr_wdata
);
   import qlet_pkg::*;

   logic    op_valid;
   logic    op_ready;
   op_type  op;
   rsp_type out_item;

   // The front end only decodes, clamps and buffers, so its two-word queue takes
   // requests while a long trim runs in the engine, until the queue is full.
   qlet_front #(
      .SIZE_BITS (SIZE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_sid     (req_tdata[30:0]),
      .req_reserve (req_tdata[70:31]),
      .req_size    (req_tdata[110:71]),
      .op_valid    (op_valid),
      .op_ready    (op_ready),
      .op          (op)
   );

   qlet_engine #(
      .ENTRIES   (ENTRIES),
      .SIZE_BITS (SIZE_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op        (op),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // Result word layout, highest bits first; the top four bits pad to bytes.
   assign rsp_tdata = {4'b0000,
                       out_item.stuck_pinned,
                       out_item.entry_count,
                       out_item.total_bytes,
                       out_item.status,
                       out_item.entry_bytes,
                       out_item.result_id};
   assign rsp_tuser = out_item.is_eviction;
   assign rsp_tlast = out_item.last;

endmodule
